/* src/gray_binomial_downscale_2x_defines.svh */
// Assertion macros for the gray binomial 2x downscaler.
`ifndef GRAY_BINOMIAL_DOWNSCALE_2X_DEFINES_SVH
`define GRAY_BINOMIAL_DOWNSCALE_2X_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define GBD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gbd assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define GBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gbd assertion failed");

`endif

/* src/gbd_pkg.sv */
// Shared types, constants and helper functions of the gray binomial 2x downscaler.
`default_nettype none

package gbd_pkg;

  localparam int DEFAULT_MAX_WIDTH = 4096;
  localparam int MAX_HEIGHT        = 4096;
  localparam int PIX_W             = 8;
  localparam int CFG_W             = 13;
  localparam int IDX_W             = 2;
  localparam int COORD_W           = 11;
  localparam int ROW_W             = 12;
  localparam int SUM_W             = 11;
  localparam int TOT_W             = 14;
  localparam int POS_W             = 14;
  localparam int QUEUE_DEPTH       = 4;
  localparam int ROUND_ADD         = 32;
  localparam int ROUND_SHIFT       = 6;
  localparam int RESET_WIDTH       = 640;
  localparam int RESET_HEIGHT      = 480;

  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;

  typedef logic [1:0] tap_dist_t;

  // per candidate output (two per axis): hit flag and distance back to each of 4 taps
  typedef struct packed {
    logic [1:0]                hit;
    tap_dist_t [1:0][3:0]      span;
  } win_class_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pix;
    logic [1:0]         rmod;
    logic               col0;
    win_class_t         rcls;
    win_class_t         ccls;
    logic [COORD_W-1:0] oy_base;
    logic [COORD_W-1:0] ox_base;
  } desc_t;

  function automatic win_class_t classify(logic [POS_W-1:0] pos, logic [POS_W-1:0] last);
    win_class_t cls;
    cls = '0;
    if (!pos[0] && pos >= POS_W'(2)) begin
      cls.hit[0]  = 1'b1;
      cls.span[0] = (pos == POS_W'(2)) ? {2'd0, 2'd1, 2'd2, 2'd2} : {2'd0, 2'd1, 2'd2, 2'd3};
    end
    if (pos == last) begin
      cls.hit[1] = 1'b1;
      if (!pos[0]) begin
        cls.span[1] = (pos == POS_W'(0)) ? 8'd0 : {2'd0, 2'd0, 2'd0, 2'd1};
      end else begin
        cls.span[1] = (pos == POS_W'(1)) ? {2'd0, 2'd0, 2'd1, 2'd1} : {2'd0, 2'd0, 2'd1, 2'd2};
      end
    end
    return cls;
  endfunction

  // a + 3*(b + c) + d
  function automatic logic [TOT_W-1:0] wsum(logic [TOT_W-1:0] a, logic [TOT_W-1:0] b,
                                            logic [TOT_W-1:0] c, logic [TOT_W-1:0] d);
    logic [TOT_W-1:0] mid;
    mid = b + c;
    return a + (mid << 1) + mid + d;
  endfunction

endpackage

`default_nettype wire

/* src/gbd_front.sv */
// Front end: config registers, raster position and per-pixel window classification.
`default_nettype none

module gbd_front #(
  parameter int MAX_WIDTH = gbd_pkg::DEFAULT_MAX_WIDTH,
  parameter int COL_W     = $clog2(MAX_WIDTH)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [gbd_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [gbd_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                      in_valid,
  input  wire logic [gbd_pkg::PIX_W-1:0] pixel_in,
  output logic                           in_stall,
  input  wire logic                      q_full,
  output logic                           push,
  output gbd_pkg::desc_t                 desc,
  output logic [COL_W-1:0]               desc_col,
  output logic                           restart
);

  logic [COL_W-1:0]          col;
  logic [gbd_pkg::ROW_W-1:0] row;
  logic [1:0]                rmod;
  logic [COL_W-1:0]          last_col;
  logic [gbd_pkg::ROW_W-1:0] last_row;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign restart  = cfg_we && (cfg_index == gbd_pkg::REG_WIDTH ||
                               cfg_index == gbd_pkg::REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_col <= COL_W'(gbd_pkg::RESET_WIDTH - 1);
      last_row <= gbd_pkg::ROW_W'(gbd_pkg::RESET_HEIGHT - 1);
    end else if (cfg_we) begin
      if (cfg_index == gbd_pkg::REG_WIDTH) begin
        if (cfg_data == '0) begin
          last_col <= '0;
        end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
          last_col <= COL_W'(MAX_WIDTH - 1);
        end else begin
          last_col <= COL_W'(cfg_data - gbd_pkg::CFG_W'(1));
        end
      end
      if (cfg_index == gbd_pkg::REG_HEIGHT) begin
        if (cfg_data == '0) begin
          last_row <= '0;
        end else if (32'(cfg_data) > 32'(gbd_pkg::MAX_HEIGHT)) begin
          last_row <= gbd_pkg::ROW_W'(gbd_pkg::MAX_HEIGHT - 1);
        end else begin
          last_row <= gbd_pkg::ROW_W'(cfg_data - gbd_pkg::CFG_W'(1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col  <= '0;
      row  <= '0;
      rmod <= '0;
    end else if (push) begin
      if (col == last_col) begin
        col <= '0;
        if (row == last_row) begin
          row  <= '0;
          rmod <= '0;
        end else begin
          row  <= row + gbd_pkg::ROW_W'(1);
          rmod <= (rmod == 2'd2) ? 2'd0 : rmod + 2'd1;
        end
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  always_comb begin
    desc         = '0;
    desc.pix     = pixel_in;
    desc.rmod    = rmod;
    desc.col0    = (col == '0);
    desc.rcls    = gbd_pkg::classify(gbd_pkg::POS_W'(row), gbd_pkg::POS_W'(last_row));
    desc.ccls    = gbd_pkg::classify(gbd_pkg::POS_W'(col), gbd_pkg::POS_W'(last_col));
    desc.oy_base = gbd_pkg::COORD_W'(row >> 1) - gbd_pkg::COORD_W'(1);
    desc.ox_base = gbd_pkg::COORD_W'(col >> 1) - gbd_pkg::COORD_W'(1);
    desc_col     = col;
  end

endmodule

`default_nettype wire

/* src/gbd_queue.sv */
// Short FIFO between front and back ends.
`default_nettype none

module gbd_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = gbd_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      rd_data,
  output logic                   full,
  output logic                   empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [CNT_W-1:0]  count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* src/gbd_back.sv */
// Back end: line memories, vertical sums, horizontal window and result serializer.
`default_nettype none

module gbd_back #(
  parameter int MAX_WIDTH = gbd_pkg::DEFAULT_MAX_WIDTH,
  parameter int COL_W     = $clog2(MAX_WIDTH)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        restart,
  input  wire logic                        q_empty,
  input  wire gbd_pkg::desc_t              q_desc,
  input  wire logic [COL_W-1:0]            q_col,
  output logic                             pop,
  input  wire logic                        out_stall,
  output logic                             out_valid,
  output logic [gbd_pkg::PIX_W-1:0]        pixel_out,
  output logic [gbd_pkg::COORD_W-1:0]      out_col,
  output logic [gbd_pkg::COORD_W-1:0]      out_row,
  output logic                             run_last
);

  localparam int PW = gbd_pkg::PIX_W;
  localparam int SW = gbd_pkg::SUM_W;
  localparam int TW = gbd_pkg::TOT_W;
  localparam int CW = gbd_pkg::COORD_W;

  // stage B: memory read data
  logic           b_valid;
  gbd_pkg::desc_t b_desc;
  logic [PW-1:0]  rd [3];

  // stage C: column sums
  logic           c_valid;
  gbd_pkg::desc_t c_desc;
  logic [SW-1:0]  c_sum [2];
  logic [SW-1:0]  win [2][3];

  // result serializer
  logic [3:0]     omask;
  logic [PW-1:0]  opix [4];
  logic [CW-1:0]  ocol [4];
  logic [CW-1:0]  orow [4];

  logic b_go, b_ready, c_go, c_ready, load_ok, out_take, single;
  logic [SW-1:0] b_sum [2];
  logic [PW-1:0] vtap [2][4];
  logic [SW-1:0] wv [2][3];
  logic [SW-1:0] htap [4];
  logic [TW-1:0] total;
  logic [TW-1:0] rounded;
  logic [3:0]    hmask;
  logic [PW-1:0] hpix [4];
  logic [1:0]    sel;

  function automatic logic [1:0] slot_of(logic [1:0] rmod, gbd_pkg::tap_dist_t d);
    logic [2:0] t;
    t = {1'b0, rmod} + 3'd3 - {1'b0, d};
    return (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
  endfunction

  // ---- stage A: pop and line memories ----
  assign out_take = out_valid && !out_stall;
  assign single   = (omask != '0) && ((omask & (omask - 4'd1)) == '0);
  assign load_ok  = (omask == '0) || (out_take && single);
  assign c_go     = c_valid && ((hmask == '0) || load_ok);
  assign c_ready  = !c_valid || c_go;
  assign b_go     = b_valid && c_ready;
  assign b_ready  = !b_valid || b_go;
  assign pop      = !q_empty && b_ready;

  for (genvar s = 0; s < 3; s++) begin : g_line
    logic [PW-1:0] mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (pop) begin
        rd[s] <= mem[q_col];
        if (q_desc.rmod == 2'(s)) begin
          mem[q_col] <= q_desc.pix;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_desc <= q_desc;
    end
  end

  // ---- stage B: vertical sums ----
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < 4; i++) begin
        if (b_desc.rcls.span[k][i] == 2'd0) begin
          vtap[k][i] = b_desc.pix;
        end else begin
          unique case (slot_of(b_desc.rmod, b_desc.rcls.span[k][i]))
            2'd0:    vtap[k][i] = rd[0];
            2'd1:    vtap[k][i] = rd[1];
            default: vtap[k][i] = rd[2];
          endcase
        end
      end
      b_sum[k] = SW'(gbd_pkg::wsum(TW'(vtap[k][0]), TW'(vtap[k][1]),
                                   TW'(vtap[k][2]), TW'(vtap[k][3])));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= b_go;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go) begin
      c_desc   <= b_desc;
      c_sum[0] <= b_sum[0];
      c_sum[1] <= b_sum[1];
    end
  end

  // ---- stage C: horizontal window ----
  always_comb begin
    total = '0;
    for (int k = 0; k < 2; k++) begin
      for (int t = 0; t < 3; t++) begin
        wv[k][t] = c_desc.col0 ? c_sum[k] : win[k][t];
      end
    end
    for (int k = 0; k < 2; k++) begin
      for (int j = 0; j < 2; j++) begin
        for (int i = 0; i < 4; i++) begin
          unique case (c_desc.ccls.span[j][i])
            2'd0:    htap[i] = c_sum[k];
            2'd1:    htap[i] = wv[k][0];
            2'd2:    htap[i] = wv[k][1];
            default: htap[i] = wv[k][2];
          endcase
        end
        total   = gbd_pkg::wsum(TW'(htap[0]), TW'(htap[1]), TW'(htap[2]), TW'(htap[3]));
        rounded = total + TW'(gbd_pkg::ROUND_ADD);
        hpix[2*k+j]  = PW'(rounded >> gbd_pkg::ROUND_SHIFT);
        hmask[2*k+j] = c_valid && c_desc.rcls.hit[k] && c_desc.ccls.hit[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      for (int k = 0; k < 2; k++) begin
        for (int t = 0; t < 3; t++) begin
          win[k][t] <= '0;
        end
      end
    end else if (c_go) begin
      for (int k = 0; k < 2; k++) begin
        if (c_desc.rcls.hit[k]) begin
          win[k][0] <= c_sum[k];
          win[k][1] <= wv[k][0];
          win[k][2] <= wv[k][1];
        end
      end
    end
  end

  // ---- result serializer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      omask <= '0;
    end else if (c_go && hmask != '0) begin
      omask <= hmask;
    end else if (out_take) begin
      omask <= omask & (omask - 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (c_go && hmask != '0) begin
      for (int n = 0; n < 4; n++) begin
        opix[n] <= hpix[n];
        ocol[n] <= CW'(c_desc.ox_base + CW'(n % 2));
        orow[n] <= CW'(c_desc.oy_base + CW'(n / 2));
      end
    end
  end

  always_comb begin
    priority if (omask[0]) sel = 2'd0;
    else if (omask[1])     sel = 2'd1;
    else if (omask[2])     sel = 2'd2;
    else                   sel = 2'd3;
  end

  assign out_valid = (omask != '0);
  assign pixel_out = opix[sel];
  assign out_col   = ocol[sel];
  assign out_row   = orow[sel];
  assign run_last  = single;

endmodule

`default_nettype wire

/* src/gray_binomial_downscale_2x.sv */
// Gray binomial [1,3,3,1] 2x downscaler, top level.
// Throughput: one source pixel per cycle unless in_stall is raised; a pixel that
//   completes n outputs (n up to 4 at the right and bottom edges) offers them in turn.
// An output word passes from its last source pixel through the queue, the line memory
//   read, the vertical sum and the horizontal sum into the output register, then is offered.
// Reset: position (0,0), width 640, height 480; line memories are not cleared.
`default_nettype none

`include "gray_binomial_downscale_2x_defines.svh"

module gray_binomial_downscale_2x #(
  parameter int MAX_WIDTH = gbd_pkg::DEFAULT_MAX_WIDTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [gbd_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [gbd_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [gbd_pkg::PIX_W-1:0]   pixel_in,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [gbd_pkg::PIX_W-1:0]        pixel_out,
  output logic [gbd_pkg::COORD_W-1:0]      out_col,
  output logic [gbd_pkg::COORD_W-1:0]      out_row,
  output logic                             run_last
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int DESC_W = $bits(gbd_pkg::desc_t);
  localparam int DATA_W = DESC_W + COL_W;

  logic              q_push, q_pop, q_full, q_empty, restart;
  gbd_pkg::desc_t    f_desc;
  logic [COL_W-1:0]  f_col;
  logic [DATA_W-1:0] q_rd;

  gbd_front #(.MAX_WIDTH(MAX_WIDTH), .COL_W(COL_W)) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .pixel_in (pixel_in),
    .in_stall (in_stall),
    .q_full   (q_full),
    .push     (q_push),
    .desc     (f_desc),
    .desc_col (f_col),
    .restart  (restart)
  );

  gbd_queue #(.DATA_W(DATA_W), .DEPTH(gbd_pkg::QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_data({f_desc, f_col}),
    .pop    (q_pop),
    .rd_data(q_rd),
    .full   (q_full),
    .empty  (q_empty)
  );

  gbd_back #(.MAX_WIDTH(MAX_WIDTH), .COL_W(COL_W)) u_back (
    .clk      (clk),
    .rst      (rst),
    .restart  (restart),
    .q_empty  (q_empty),
    .q_desc   (gbd_pkg::desc_t'(q_rd[DATA_W-1:COL_W])),
    .q_col    (q_rd[COL_W-1:0]),
    .pop      (q_pop),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .pixel_out(pixel_out),
    .out_col  (out_col),
    .out_row  (out_row),
    .run_last (run_last)
  );

  `GBD_ASSERT_NOW(a_pop_not_empty, q_pop, !q_empty)
  `GBD_ASSERT_NOW(a_queue_sane, q_full, !q_empty)
  `GBD_ASSERT_NEXT(a_burst_continues, out_valid && !out_stall && !run_last, out_valid)

endmodule

`default_nettype wire
